[rtl/ais_position_sentence_encoder_top_assert.svh]
// Assertion macros for the AIS position sentence encoder.
`ifndef AIS_POSITION_SENTENCE_ENCODER_TOP_ASSERT_SVH
`define AIS_POSITION_SENTENCE_ENCODER_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define AISPSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aispse: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define AISPSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aispse: next-cycle check failed");

`endif

[rtl/aispse_pkg.sv]
// Shared constants, types and helper functions of the AIS position sentence encoder.
`default_nettype none

package aispse_pkg;

    // Input word layout (s_tdata), lowest bit first
    localparam int IN_DATA_W  = 136;
    localparam int MMSI_LSB   = 0;
    localparam int NAV_LSB    = 30;
    localparam int SOG_LSB    = 34;
    localparam int LAT_LSB    = 44;
    localparam int LON_LSB    = 72;
    localparam int COG_LSB    = 101;
    localparam int HDG_LSB    = 113;
    localparam int SEC_LSB    = 122;
    localparam int CHAN_LSB   = 128;

    localparam int OUT_DATA_W = 8;
    localparam int MSG_BITS   = 168;
    localparam int DVD_W      = 30;
    localparam int DIGIT_W    = 3;
    localparam int DIV_DIGITS = DVD_W / DIGIT_W;

    localparam logic [5:0] TYPE1_ID           = 6'd1;
    localparam logic [5:0] TYPE18_ID          = 6'd18;
    localparam logic [26:0] TYPE18_RADIO_STATE = 27'd393222;

    localparam logic [1:0] CHAN_NONE = 2'd0;
    localparam logic [1:0] CHAN_A    = 2'd1;
    localparam logic [1:0] CHAN_B    = 2'd2;

    // Sentence text
    localparam int         HEAD_LEN  = 12;
    localparam logic [95:0] HEAD_TEXT = "!AIVDM,1,1,,";
    localparam logic [6:0] CH_A      = 7'h41;
    localparam logic [6:0] CH_B      = 7'h42;
    localparam logic [6:0] CH_COMMA  = 7'h2c;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_STAR   = 7'h2a;
    localparam logic [6:0] HEX_ALPHA_OFS = 7'h37;
    localparam logic [5:0] ARMOR_SPLIT    = 6'd40;
    localparam logic [6:0] ARMOR_HIGH_OFS = 7'd56;

    // Sentence byte positions
    localparam logic [5:0] POS_BANG     = 6'd0;
    localparam logic [5:0] POS_HEAD1    = 6'd1;
    localparam logic [5:0] POS_HEAD_END = 6'd11;
    localparam logic [5:0] POS_CHAN     = 6'd12;
    localparam logic [5:0] POS_COMMA1   = 6'd13;
    localparam logic [5:0] POS_PAY0     = 6'd14;
    localparam logic [5:0] POS_PAY_END  = 6'd41;
    localparam logic [5:0] POS_COMMA2   = 6'd42;
    localparam logic [5:0] POS_FILL     = 6'd43;
    localparam logic [5:0] POS_STAR     = 6'd44;
    localparam logic [5:0] POS_HI       = 6'd45;
    localparam logic [5:0] POS_LO       = 6'd46;

    typedef struct packed {
        logic [2:0] q;
        logic [2:0] r;
    } div5_t;

    // One radix-8 digit of division by five: v is remainder*8 + digit, below 40.
    function automatic div5_t div5_step(input logic [5:0] v);
        logic [2:0] q;
        logic [5:0] r;
        div5_t      d;
        q = 3'd0;
        for (int k = 1; k < 8; k++)
        begin
            if (v >= 6'(5 * k))
            begin
                q = 3'(k);
            end
        end
        r = v - (6'({q, 2'b00}) + 6'(q));
        d.q = q;
        d.r = r[2:0];
        return d;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (CH_ZERO + {3'b000, n}) : (HEX_ALPHA_OFS + {3'b000, n});
    endfunction

    function automatic logic [6:0] armor_char(input logic [5:0] v);
        return (v < ARMOR_SPLIT) ? (CH_ZERO + {1'b0, v}) : ({1'b0, v} + ARMOR_HIGH_OFS);
    endfunction

endpackage

`default_nettype wire

[rtl/ais_position_sentence_encoder_top.sv]
// Top level of the AIS position sentence encoder: report in, !AIVDM bytes out.
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  ----------------------------------------------
//  s_*      in   s_tvalid/s_tready  tuser: mode; tdata: position report fields
//  m_*      out  m_tvalid/m_tready  tdata: sentence_char; tlast: final hex digit
//
// One report yields 46 bytes (no channel letter) or 47 bytes, one word per cycle
// through the output register while m_tready stays high; the next report is
// taken in the cycle the final digit is loaded.
// Latitude and longitude are scaled by 3/5 in a radix-8 digit-serial divider
// (a prep step, then the digit steps) that runs while the header bytes go out.
// Reset (rst_n, asynchronous) clears all control state; no clearing pass.
// m_tready low holds the output word and stalls the byte sequencer.
`default_nettype none

module ais_position_sentence_encoder_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata from bit 0 up: mmsi(30), nav_code(4), speed_tenths(10),
    // latitude_microdeg(28), longitude_microdeg(29), course_tenths(12),
    // heading_deg(9), utc_second(6), radio_channel(2), zero fill(6)
    input  wire logic [aispse_pkg::IN_DATA_W-1:0] s_tdata,
    // tuser: mode(1)
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata from bit 0 up: sentence_char(7), zero fill(1)
    output logic [aispse_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                  m_tlast
);

    import aispse_pkg::*;

`include "ais_position_sentence_encoder_top_assert.svh"

    typedef enum logic [1:0] {C_IDLE, C_PREP, C_DIV, C_LOAD} calc_state_t;

    // Captured report fields
    logic        mode_reg;
    logic [29:0] mmsi_reg;
    logic [3:0]  nav_reg;
    logic [9:0]  sog_reg;
    logic [11:0] cog_reg;
    logic [8:0]  hdg_reg;
    logic [5:0]  sec_reg;
    logic [1:0]  chan_reg, chan_next;

    // Divider lanes
    logic             lat_neg_reg, lon_neg_reg;
    logic [DVD_W-1:0] lat_dvd_reg, lat_dvd_next, lon_dvd_reg, lon_dvd_next;
    logic [DVD_W-1:0] lat_quo_reg, lat_quo_next, lon_quo_reg, lon_quo_next;
    logic [2:0]       lat_rem_reg, lat_rem_next, lon_rem_reg, lon_rem_next;
    logic [3:0]       digit_cnt_reg, digit_cnt_next;
    calc_state_t      calc_state_reg, calc_state_next;

    // Message and sequencer
    logic [MSG_BITS-1:0] msg_reg, msg_next;
    logic                msg_ready_reg, msg_ready_next;
    logic [5:0]          pos_reg, pos_next;
    logic [7:0]          cks_reg, cks_next;
    logic                emit_active_reg, emit_active_next;
    logic                out_valid_reg, out_valid_next;
    logic [6:0]          out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;

    logic        accept;
    logic        in_payload;
    logic        load_ok;
    logic [6:0]  cur_char;
    logic [27:0] lat_in, lat_abs;
    logic [28:0] lon_in, lon_abs;
    logic [DVD_W-1:0] lat_signed, lon_signed;
    div5_t       lat_step, lon_step;

    assign lat_in  = s_tdata[LAT_LSB +: 28];
    assign lon_in  = s_tdata[LON_LSB +: 29];
    assign lat_abs = lat_in[27] ? (~lat_in + 28'd1) : lat_in;
    assign lon_abs = lon_in[28] ? (~lon_in + 29'd1) : lon_in;

    assign lat_step = div5_step({lat_rem_reg, lat_dvd_reg[DVD_W-1 -: DIGIT_W]});
    assign lon_step = div5_step({lon_rem_reg, lon_dvd_reg[DVD_W-1 -: DIGIT_W]});

    // Truncating toward zero: divide the magnitude, then restore the sign
    assign lat_signed = lat_neg_reg ? (~lat_quo_reg + 30'd1) : lat_quo_reg;
    assign lon_signed = lon_neg_reg ? (~lon_quo_reg + 30'd1) : lon_quo_reg;

    assign in_payload = (pos_reg >= POS_PAY0) && (pos_reg <= POS_PAY_END);
    assign load_ok    = emit_active_reg && (!out_valid_reg || m_tready) &&
                        (!in_payload || msg_ready_reg);
    assign s_tready   = !emit_active_reg || (load_ok && (pos_reg == POS_LO));
    assign accept     = s_tvalid && s_tready;

    // Byte for the current sentence position
    always_comb
    begin
        cur_char = 7'd0;
        case (pos_reg) inside
            [POS_BANG:POS_HEAD_END]:
                cur_char = HEAD_TEXT[8 * (HEAD_LEN - 1 - int'(pos_reg)) +: 7];
            POS_CHAN:
                cur_char = (chan_reg == CHAN_A) ? CH_A : CH_B;
            POS_COMMA1, POS_COMMA2:
                cur_char = CH_COMMA;
            [POS_PAY0:POS_PAY_END]:
                cur_char = armor_char(msg_reg[MSG_BITS-1 -: 6]);
            POS_FILL:
                cur_char = CH_ZERO;
            POS_STAR:
                cur_char = CH_STAR;
            POS_HI:
                cur_char = hex_char(cks_reg[7:4]);
            POS_LO:
                cur_char = hex_char(cks_reg[3:0]);
            default:
                cur_char = 7'd0;
        endcase
    end

    always_comb
    begin
        chan_next        = chan_reg;
        lat_dvd_next     = lat_dvd_reg;
        lon_dvd_next     = lon_dvd_reg;
        lat_quo_next     = lat_quo_reg;
        lon_quo_next     = lon_quo_reg;
        lat_rem_next     = lat_rem_reg;
        lon_rem_next     = lon_rem_reg;
        digit_cnt_next   = digit_cnt_reg;
        calc_state_next  = calc_state_reg;
        msg_next         = msg_reg;
        msg_ready_next   = msg_ready_reg;
        pos_next         = pos_reg;
        cks_next         = cks_reg;
        emit_active_next = emit_active_reg;
        out_valid_next   = out_valid_reg;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;

        // Divider sequence
        unique case (calc_state_reg)
            C_IDLE:
            begin
            end
            C_PREP:
            begin
                // Triple the magnitudes before dividing by five
                lat_dvd_next    = lat_dvd_reg + {lat_dvd_reg[DVD_W-2:0], 1'b0};
                lon_dvd_next    = lon_dvd_reg + {lon_dvd_reg[DVD_W-2:0], 1'b0};
                lat_rem_next    = 3'd0;
                lon_rem_next    = 3'd0;
                digit_cnt_next  = 4'd0;
                calc_state_next = C_DIV;
            end
            C_DIV:
            begin
                lat_quo_next = {lat_quo_reg[DVD_W-DIGIT_W-1:0], lat_step.q};
                lon_quo_next = {lon_quo_reg[DVD_W-DIGIT_W-1:0], lon_step.q};
                lat_rem_next = lat_step.r;
                lon_rem_next = lon_step.r;
                lat_dvd_next = {lat_dvd_reg[DVD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                lon_dvd_next = {lon_dvd_reg[DVD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                digit_cnt_next = digit_cnt_reg + 4'd1;
                if (digit_cnt_reg == 4'(DIV_DIGITS - 1))
                begin
                    calc_state_next = C_LOAD;
                end
            end
            C_LOAD:
            begin
                if (mode_reg)
                begin
                    msg_next = {TYPE18_ID, 2'd0, mmsi_reg, 8'd0, sog_reg, 1'b1,
                                lon_signed[27:0], lat_signed[26:0], cog_reg, hdg_reg,
                                sec_reg, 2'd0, TYPE18_RADIO_STATE};
                end
                else
                begin
                    msg_next = {TYPE1_ID, 2'd0, mmsi_reg, nav_reg, 8'd0, sog_reg, 1'b0,
                                lon_signed[27:0], lat_signed[26:0], cog_reg, hdg_reg,
                                sec_reg, 25'd0};
                end
                msg_ready_next  = 1'b1;
                calc_state_next = C_IDLE;
            end
            default:
            begin
                calc_state_next = C_IDLE;
            end
        endcase

        // Output register drains independently of the sequencer
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_ok)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_char;
            out_last_next  = (pos_reg == POS_LO);
            if ((pos_reg >= POS_HEAD1) && (pos_reg <= POS_FILL))
            begin
                cks_next = cks_reg ^ {1'b0, cur_char};
            end
            if (in_payload)
            begin
                msg_next = {msg_reg[MSG_BITS-7:0], 6'd0};
            end
            // Skip the channel letter when the field is empty
            if ((pos_reg == POS_HEAD_END) && (chan_reg == CHAN_NONE))
            begin
                pos_next = POS_COMMA1;
            end
            else
            begin
                pos_next = pos_reg + 6'd1;
            end
            if (pos_reg == POS_LO)
            begin
                emit_active_next = 1'b0;
            end
        end

        // A new report restarts the sentence
        if (accept)
        begin
            chan_next        = (s_tdata[CHAN_LSB +: 2] == CHAN_A ||
                                s_tdata[CHAN_LSB +: 2] == CHAN_B) ?
                               s_tdata[CHAN_LSB +: 2] : CHAN_NONE;
            lat_dvd_next     = {2'b00, lat_abs};
            lon_dvd_next     = {1'b0, lon_abs};
            msg_ready_next   = 1'b0;
            calc_state_next  = C_PREP;
            pos_next         = POS_BANG;
            cks_next         = 8'd0;
            emit_active_next = 1'b1;
        end
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_state_reg  <= C_IDLE;
            digit_cnt_reg   <= 4'd0;
            msg_ready_reg   <= 1'b0;
            msg_reg         <= '0;
            pos_reg         <= 6'd0;
            cks_reg         <= 8'd0;
            chan_reg        <= CHAN_NONE;
            emit_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_char_reg    <= 7'd0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            calc_state_reg  <= calc_state_next;
            digit_cnt_reg   <= digit_cnt_next;
            msg_ready_reg   <= msg_ready_next;
            msg_reg         <= msg_next;
            pos_reg         <= pos_next;
            cks_reg         <= cks_next;
            chan_reg        <= chan_next;
            emit_active_reg <= emit_active_next;
            out_valid_reg   <= out_valid_next;
            out_char_reg    <= out_char_next;
            out_last_reg    <= out_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= s_tuser;
            mmsi_reg    <= s_tdata[MMSI_LSB +: 30];
            nav_reg     <= s_tdata[NAV_LSB +: 4];
            sog_reg     <= s_tdata[SOG_LSB +: 10];
            cog_reg     <= s_tdata[COG_LSB +: 12];
            hdg_reg     <= s_tdata[HDG_LSB +: 9];
            sec_reg     <= s_tdata[SEC_LSB +: 6];
            lat_neg_reg <= lat_in[27];
            lon_neg_reg <= lon_in[28];
        end
        lat_dvd_reg  <= lat_dvd_next;
        lon_dvd_reg  <= lon_dvd_next;
        lat_quo_reg  <= lat_quo_next;
        lon_quo_reg  <= lon_quo_next;
        lat_rem_reg  <= lat_rem_next;
        lon_rem_reg  <= lon_rem_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;

    // The divider must be done before the next report is taken
    `AISPSE_ASSERT_NOW(a_accept_calc_idle, accept, calc_state_reg == C_IDLE)
    // Payload sextets are only sent from a loaded message
    `AISPSE_ASSERT_NOW(a_payload_msg_ready, load_ok && in_payload, msg_ready_reg)
    // Sequencer never runs past the final checksum digit
    `AISPSE_ASSERT_NOW(a_pos_bound, emit_active_reg, pos_reg <= POS_LO)
    // Message load completes the scaling pass
    `AISPSE_ASSERT_NEXT(a_load_sets_ready, calc_state_reg == C_LOAD && !accept, msg_ready_reg)

endmodule

`default_nettype wire
